// ----- hdl/bsls_pkg.sv -----
// Package: shared types, constants and byte classification for the sanitizer.
`default_nettype none
package bsls_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
	localparam logic [BYTE_W-1:0] CH_FF         = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_BACKSPACE  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COMMA      = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LOWER_A    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_UPPER_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9    = 8'h39;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STRICT_MODE = 2'd0,
		CFG_MAX_LEN     = 2'd1
	} cfg_idx_t;

	// One classified word between front and back
	typedef struct packed {
		logic              split;
		logic [BYTE_W-1:0] data;
	} item_t;

	// Byte allowed under the selected mode
	function automatic logic byte_allowed(input logic [BYTE_W-1:0] b, input logic strict);
		logic common;
		logic alnum;
		logic punct;
		common = (b == CH_NEWLINE) || (b == CH_SPACE) || (b == CH_CR) ||
			(b == CH_TAB) || (b == CH_FF);
		alnum = ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
			((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
			((b >= CH_DIGIT_0) && (b <= CH_DIGIT_9));
		punct = (b == CH_MINUS) || (b == CH_PLUS) || (b == CH_DOT) || (b == CH_COMMA);
		if (common) begin
			return 1'b1;
		end else if (strict) begin
			return alnum || punct;
		end else begin
			return (b >= CH_SPACE) || (b == CH_BACKSPACE);
		end
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bsls_in_if.sv -----
// Interface: raw byte input channel.
`default_nettype none
interface bsls_in_if;
	logic                         valid;
	logic                         ready;
	logic [bsls_pkg::BYTE_W-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsls_out_if.sv -----
// Interface: sanitized byte output channel.
`default_nettype none
interface bsls_out_if;
	logic                         valid;
	logic                         ready;
	logic [bsls_pkg::BYTE_W-1:0]  out_byte;
	logic                         last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsls_cfg_if.sv -----
// Interface: configuration register write channel.
`default_nettype none
interface bsls_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bsls_pkg::CFG_IDX_W-1:0]   index;
	logic [bsls_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsls_front.sv -----
// Front: configuration registers, byte filtering and line-length tracking.
`default_nettype none
module bsls_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	bsls_in_if.sink           raw,
	bsls_cfg_if.sink          cfg,
	input  wire logic         q_full,
	output logic              q_push,
	output bsls_pkg::item_t   q_item
);

	logic                          strict_q;
	logic [bsls_pkg::LEN_W-1:0]    max_len_q;
	logic [bsls_pkg::LEN_W-1:0]    count_q;
	logic [bsls_pkg::BYTE_W-1:0]   clean_byte;
	logic [bsls_pkg::LEN_W:0]      next_count;
	logic                          split;

	// Take register writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q  <= 1'b0;
			max_len_q <= bsls_pkg::MAX_LEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bsls_pkg::CFG_STRICT_MODE: strict_q <= cfg.data[0];
				bsls_pkg::CFG_MAX_LEN:     max_len_q <= cfg.data[bsls_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Replace disallowed bytes and look ahead at the line count
	always_comb begin
		clean_byte = bsls_pkg::byte_allowed(raw.in_byte, strict_q) ?
			raw.in_byte : bsls_pkg::CH_UNDERSCORE;
		if (clean_byte == bsls_pkg::CH_NEWLINE) begin
			next_count = '0;
		end else begin
			next_count = {1'b0, count_q} + {{bsls_pkg::LEN_W{1'b0}}, 1'b1};
		end
		split = next_count > {1'b0, max_len_q};
	end

	assign raw.ready    = !q_full;
	assign q_push       = raw.valid && !q_full;
	assign q_item.split = split;
	assign q_item.data  = clean_byte;

	// Advance the line count on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= split ? {{(bsls_pkg::LEN_W-1){1'b0}}, 1'b1} :
				next_count[bsls_pkg::LEN_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bsls_queue.sv -----
// Queue: short FIFO of classified words between front and back.
`default_nettype none
module bsls_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bsls_pkg::item_t    push_item,
	input  wire logic               pop,
	output bsls_pkg::item_t         head,
	output logic                    empty,
	output logic                    full
);

	bsls_pkg::item_t                  mem_q [bsls_pkg::QUEUE_DEPTH];
	logic [bsls_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bsls_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bsls_pkg::QCNT_W-1:0]      cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == bsls_pkg::QCNT_W'(bsls_pkg::QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Hold the payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bsls_pkg::QPTR_W'(bsls_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bsls_pkg::QPTR_W'(bsls_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bsls_back.sv -----
// Back: expands each word into one result, or newline, space and byte on a split.
`default_nettype none
module bsls_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bsls_pkg::item_t    head,
	input  wire logic               empty,
	output logic                    pop,
	bsls_out_if.source              clean
);

	typedef enum logic [2:0] {
		ST_FIRST = 3'b001,
		ST_SPACE = 3'b010,
		ST_BYTE  = 3'b100
	} phase_t;

	phase_t                        phase_q;
	phase_t                        phase_nxt;
	logic                          out_valid_q;
	logic [bsls_pkg::BYTE_W-1:0]   out_byte_q;
	logic                          out_last_q;
	logic                          can_load;
	logic                          step;
	logic [bsls_pkg::BYTE_W-1:0]   emit_byte;
	logic                          emit_last;

	assign can_load = !out_valid_q || clean.ready;
	assign step     = can_load && !empty;

	// Pick the next result of the head word
	always_comb begin
		phase_nxt = phase_q;
		emit_byte = head.data;
		emit_last = 1'b1;
		case (phase_q)
			ST_FIRST: begin
				if (head.split) begin
					emit_byte = bsls_pkg::CH_NEWLINE;
					emit_last = 1'b0;
					phase_nxt = ST_SPACE;
				end
			end
			ST_SPACE: begin
				emit_byte = bsls_pkg::CH_SPACE;
				emit_last = 1'b0;
				phase_nxt = ST_BYTE;
			end
			ST_BYTE: begin
				phase_nxt = ST_FIRST;
			end
			default: begin
				phase_nxt = ST_FIRST;
			end
		endcase
	end

	assign pop = step && emit_last;

	// Advance the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_FIRST;
		end else if (step) begin
			phase_q <= phase_nxt;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	assign clean.valid       = out_valid_q;
	assign clean.out_byte    = out_byte_q;
	assign clean.last_of_run = out_last_q;

endmodule
`default_nettype wire

// ----- hdl/byte_sanitizer_line_splitter.sv -----
// Top level: byte sanitizer and line splitter.
// One byte is accepted per clock while the queue is not full. Each byte yields
// one output word, or three (newline, space, byte) when the line would exceed
// max_line_length; the front keeps taking bytes into a two-word queue while a
// split byte holds the output side, so a stream with rare splits runs at one
// byte per cycle while the output is ready. An accepted byte is registered in
// the queue and then in the output register. Configuration writes are taken
// every cycle and should only be issued while the block is idle.
`default_nettype none
module byte_sanitizer_line_splitter (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bsls_in_if.sink        raw,
	bsls_out_if.source     clean,
	bsls_cfg_if.sink       cfg
);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	bsls_pkg::item_t  q_item;
	bsls_pkg::item_t  q_head;

	bsls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_item)
	);

	bsls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	bsls_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.clean  (clean)
	);

	// Never write a full queue nor read an empty one
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full) && !(q_pop && q_empty))
		else $error("queue overflow or underflow");

	// A word that is not last of its run is an inserted newline or space
	a_inserted_only: assert property (@(posedge clk) disable iff (!arst_n)
		(clean.valid && !clean.last_of_run) |->
		(clean.out_byte == bsls_pkg::CH_NEWLINE || clean.out_byte == bsls_pkg::CH_SPACE))
		else $error("non-final word is not newline or space");

	// An inserted newline is followed at once by the inserted space
	a_space_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(clean.valid && clean.ready && !clean.last_of_run &&
			clean.out_byte == bsls_pkg::CH_NEWLINE) |=>
		(clean.valid && !clean.last_of_run && clean.out_byte == bsls_pkg::CH_SPACE))
		else $error("inserted newline not followed by space");

endmodule
`default_nettype wire
